FILE: rtl/core/vlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlpd_pkg;

	localparam int MAX_PREFIX_BYTES = 5;
	localparam int GROUP_BITS       = 7;
	localparam int BYTE_W           = 8;
	localparam int LEN_W            = 31;
	localparam int CNT_W            = 3;

	// Wide enough for every group shifted into place, and for one bit above LEN_W.
	localparam int ACC_W = (GROUP_BITS * MAX_PREFIX_BYTES > LEN_W) ?
		GROUP_BITS * MAX_PREFIX_BYTES : LEN_W + 1;
	localparam int SH_W  = $clog2(ACC_W);

	localparam logic [BYTE_W-1:0] DATA_MASK = BYTE_W'(127);
	localparam logic [BYTE_W-1:0] CONT_BIT  = BYTE_W'(128);

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  byte_offset;
		logic [LEN_W-1:0]  message_length;
		logic              last_of_message;
		logic              prefix_error;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/vlpd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vlpd_in_if;
	logic                         valid;
	logic                         ready;
	logic [vlpd_pkg::BYTE_W-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface vlpd_out_if;
	logic                         valid;
	logic                         ready;
	logic [vlpd_pkg::BYTE_W-1:0]  payload_byte;
	logic [vlpd_pkg::LEN_W-1:0]   byte_offset;
	logic [vlpd_pkg::LEN_W-1:0]   message_length;
	logic                         last_of_message;
	logic                         prefix_error;

	modport source (output valid, output payload_byte, output byte_offset,
		output message_length, output last_of_message, output prefix_error,
		input ready);
	modport sink   (input valid, input payload_byte, input byte_offset,
		input message_length, input last_of_message, input prefix_error,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/varint_length_prefixed_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                        Request handshake
// in_ch     in         in_byte                                        valid/ready
// out_ch    out        payload_byte, byte_offset, message_length,     valid/ready
//                      last_of_message, prefix_error
//
// One byte is accepted per cycle unless in_ch is held off. A request lands in the input
// register when it is accepted, and its result is loaded into the result register when
// the input register advances, so results are offered from the result register.
// Prefix bytes give no result, apart from the byte that reveals a prefix error, and a
// zero length prefix gives none at all; bytes without a result never wait on out_ch.
// Reset clears the parser to expect a length prefix and empties both registers.
// While a result waits on out_ch, bytes without a result still pass, and the first byte
// that gives one waits in the input register and holds off in_ch.

module varint_length_prefixed_deframer (
	input  wire          clk,
	input  wire          arst_n,
	vlpd_in_if.sink      in_ch,
	vlpd_out_if.source   out_ch
);
	import vlpd_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic                in_prefix_q;
	logic [LEN_W-1:0]    length_accum_q;
	logic [CNT_W-1:0]    group_cnt_q;
	logic [LEN_W-1:0]    cur_len_q;
	logic [LEN_W-1:0]    pos_q;

	logic                out_valid_q;
	res_t                out_res_q;

	logic [SH_W-1:0]     shamt;
	logic [ACC_W-1:0]    group_val;
	logic [ACC_W-1:0]    acc_val;
	logic                more;
	logic                too_big;
	logic                overlong;
	logic                pay_last;
	logic [LEN_W:0]      pos_inc;
	logic                has_res;
	logic                adv_s1;
	logic                fire_s1;
	res_t                res;

	always_comb begin
		shamt     = SH_W'(GROUP_BITS * int'(group_cnt_q));
		group_val = ACC_W'(byte_s1 & DATA_MASK) << shamt;
		acc_val   = ACC_W'(length_accum_q) | group_val;
		more      = (byte_s1 & CONT_BIT) != '0;
		too_big   = |acc_val[ACC_W-1:LEN_W];
		overlong  = more && (group_cnt_q >= CNT_W'(MAX_PREFIX_BYTES - 1));
		pos_inc   = {1'b0, pos_q} + (LEN_W+1)'(1);
		pay_last  = pos_inc >= {1'b0, cur_len_q};

		if (in_prefix_q) begin
			has_res = too_big || overlong;
			res     = '{payload_byte: '0, byte_offset: '0, message_length: '0,
				last_of_message: 1'b0, prefix_error: 1'b1};
		end else begin
			has_res = 1'b1;
			res     = '{payload_byte: byte_s1, byte_offset: pos_q,
				message_length: cur_len_q, last_of_message: pay_last,
				prefix_error: 1'b0};
		end
	end

	assign adv_s1      = !has_res || !out_valid_q || out_ch.ready;
	assign fire_s1     = valid_s1 && adv_s1;
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_prefix_q    <= 1'b1;
			length_accum_q <= '0;
			group_cnt_q    <= '0;
			cur_len_q      <= '0;
			pos_q          <= '0;
		end else if (fire_s1) begin
			if (in_prefix_q) begin
				if (too_big || overlong) begin
					length_accum_q <= '0;
					group_cnt_q    <= '0;
				end else if (more) begin
					length_accum_q <= acc_val[LEN_W-1:0];
					group_cnt_q    <= group_cnt_q + CNT_W'(1);
				end else begin
					length_accum_q <= '0;
					group_cnt_q    <= '0;
					// A zero length prefix leaves the parser waiting for the next prefix.
					if (acc_val != '0) begin
						in_prefix_q <= 1'b0;
						cur_len_q   <= acc_val[LEN_W-1:0];
						pos_q       <= '0;
					end
				end
			end else if (pay_last) begin
				in_prefix_q    <= 1'b1;
				length_accum_q <= '0;
				group_cnt_q    <= '0;
				pos_q          <= '0;
			end else begin
				pos_q <= pos_inc[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_res) begin
			out_res_q <= res;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.payload_byte    = out_res_q.payload_byte;
	assign out_ch.byte_offset     = out_res_q.byte_offset;
	assign out_ch.message_length  = out_res_q.message_length;
	assign out_ch.last_of_message = out_res_q.last_of_message;
	assign out_ch.prefix_error    = out_res_q.prefix_error;

endmodule

`default_nettype wire

FILE: rtl/core/vlpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vlpd_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire [vlpd_pkg::BYTE_W-1:0]   payload_byte,
	input  wire [vlpd_pkg::LEN_W-1:0]    byte_offset,
	input  wire [vlpd_pkg::LEN_W-1:0]    message_length,
	input  wire                          last_of_message,
	input  wire                          prefix_error
);
	import vlpd_pkg::*;

	// A stalled result keeps its valid and its payload byte, offset, length and error flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_offset) &&
		$stable(message_length) && $stable(payload_byte) && $stable(prefix_error))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefix_error |-> payload_byte == '0 && byte_offset == '0 &&
		message_length == '0 && !last_of_message)
		else $error("error result carries payload fields");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prefix_error |-> message_length != '0 &&
		byte_offset < message_length)
		else $error("payload offset outside its message");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_message |->
		({1'b0, byte_offset} + (LEN_W+1)'(1)) == {1'b0, message_length})
		else $error("last flag not on the final byte");

endmodule

bind varint_length_prefixed_deframer vlpd_checker u_vlpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.payload_byte    (out_ch.payload_byte),
	.byte_offset     (out_ch.byte_offset),
	.message_length  (out_ch.message_length),
	.last_of_message (out_ch.last_of_message),
	.prefix_error    (out_ch.prefix_error)
);

`default_nettype wire
